FILE: hw/rtl/ifs_cgp_pkg.sv
// Shared types and constants for the IFS chaos-game plotter.
// Used by the top level and the shared multiply-accumulate unit; no dependencies.
package ifs_cgp_pkg;

  localparam int CoefW  = 16;  // packed lane width of coefficients and screen terms
  localparam int PointW = 32;  // Q16.16 point coordinate
  localparam int ProdW  = 48;  // point times coefficient
  localparam int AccW   = 49;  // two products plus a translation term
  localparam int ScrW   = 50;  // screen sum before truncation
  localparam int IdxW   = 4;
  localparam int CfgW   = 64;
  localparam int ThrW   = 15;

  // register indexes of the configuration port
  localparam logic [IdxW-1:0] REG_COEF_XX    = 4'd0;
  localparam logic [IdxW-1:0] REG_COEF_XY    = 4'd1;
  localparam logic [IdxW-1:0] REG_COEF_YX    = 4'd2;
  localparam logic [IdxW-1:0] REG_COEF_YY    = 4'd3;
  localparam logic [IdxW-1:0] REG_SHIFT_X    = 4'd4;
  localparam logic [IdxW-1:0] REG_SHIFT_Y    = 4'd5;
  localparam logic [IdxW-1:0] REG_THRESHOLDS = 4'd6;
  localparam logic [IdxW-1:0] REG_SCREEN     = 4'd7;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic mul_en;    // register a new product
    logic acc_init;  // load the accumulator with the addend
    logic acc_add;   // fold the held product into the accumulator
  } mac_ctrl_t;

  function automatic logic signed [CoefW-1:0] lane16(input logic [CfgW-1:0] word,
                                                     input logic [1:0] lane);
    lane16 = word[{lane, 4'd0} +: CoefW];
  endfunction

endpackage

FILE: hw/rtl/ifs_chaos_game_plotter_core.sv
// IFS chaos-game plotter: one item in, one pixel item out.
// Output: out_valid_o rises when the DONE state loads the pixel item register.
// Per item: accept in IDLE, six products on the shared multiplier in RUN (four affine,
// two screen scale), pixel load in DONE; no new item is taken until back in IDLE.
// Reset (rst_ni low, asynchronous): configuration registers cleared to 0, point at origin,
// no item pending; in_ready_o is high from reset on.
module ifs_chaos_game_plotter_core #(
  parameter int SCREEN_WIDTH   = 640,
  parameter int SCREEN_HEIGHT  = 480,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [ifs_cgp_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [ifs_cgp_pkg::CfgW-1:0]     cfg_wdata_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [14:0]                      random_value_i,
  input  logic [3:0]                       draw_color_i,
  input  logic                             restart_i,
  // pixel items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [9:0]                       pixel_x_o,
  output logic [8:0]                       pixel_y_o,
  output logic [3:0]                       pixel_color_o,
  output logic                             plot_enable_o
);
  import ifs_cgp_pkg::*;

  localparam logic [ScrW-17:0] WidthLim  = (ScrW-16)'(SCREEN_WIDTH);
  localparam logic [ScrW-17:0] HeightLim = (ScrW-16)'(SCREEN_HEIGHT);
  localparam logic signed [ScrW-1:0] HeightFix = ScrW'(SCREEN_HEIGHT) <<< 16;

  // Truncate v / 2^16 toward zero and test 0 <= q < lim. A negative v above
  // -2^16 truncates to zero and is on screen.
  function automatic logic scr_on(input logic [ScrW-1:0] v, input logic [ScrW-17:0] lim);
    logic [ScrW-17:0] hi;
    hi = v[ScrW-1:16];
    scr_on = (!v[ScrW-1] && (hi < lim)) || ((&hi) && (|v[15:0]));
  endfunction

  // configuration registers
  logic [CfgW-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic [CfgW-1:0] shift_x_q, shift_y_q, screen_q;
  logic [3*ThrW-1:0] thr_q;

  // sequencer
  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] map_q, map_d;
  logic [3:0] color_q;
  logic in_acc, out_load;

  // point state and partial pixel
  logic signed [PointW-1:0] point_x_q, point_y_q;
  logic [9:0] col_q;
  logic       on_x_q;

  // shared unit
  mac_ctrl_t                mac_ctrl;
  logic signed [PointW-1:0] mac_a, mac_addend, mac_point;
  logic signed [CoefW-1:0]  mac_b;
  logic signed [ProdW-1:0]  mac_prod;

  // screen sums
  logic signed [ScrW-1:0] col_v, row_v;
  logic                   on_y;

  // output register
  logic       out_valid_q;
  logic [9:0] pix_x_q;
  logic [8:0] pix_y_q;
  logic [3:0] pix_c_q;
  logic       plot_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // pick the map: the first threshold that r falls below wins
  always_comb begin
    priority if (random_value_i < thr_q[ThrW-1:0]) begin
      map_d = 2'd0;
    end else if (random_value_i < thr_q[2*ThrW-1:ThrW]) begin
      map_d = 2'd1;
    end else if (random_value_i < thr_q[3*ThrW-1:2*ThrW]) begin
      map_d = 2'd2;
    end else begin
      map_d = 2'd3;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RUN;
          cnt_d   = 3'd0;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold here while the previous pixel item still waits
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Product schedule, one per RUN cycle:
  //   0: x*xx   1: y*xy   2: x*yx   3: y*yy   4: x'*xscale   5: y'*yscale
  // x' is written at step 2 (after step 2 has read the old x), y' at step 4.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    unique case (cnt_q)
      3'd0: begin mac_a = point_x_q; mac_b = lane16(coef_xx_q, map_q); end
      3'd1: begin mac_a = point_y_q; mac_b = lane16(coef_xy_q, map_q); end
      3'd2: begin mac_a = point_x_q; mac_b = lane16(coef_yx_q, map_q); end
      3'd3: begin mac_a = point_y_q; mac_b = lane16(coef_yy_q, map_q); end
      3'd4: begin mac_a = point_x_q; mac_b = lane16(screen_q, 2'd0); end
      3'd5: begin mac_a = point_y_q; mac_b = lane16(screen_q, 2'd1); end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  assign mac_ctrl.mul_en   = (state_q == S_RUN);
  assign mac_ctrl.acc_init = (state_q == S_RUN) && ((cnt_q == 3'd0) || (cnt_q == 3'd2));
  assign mac_ctrl.acc_add  = (state_q == S_RUN) && ((cnt_q == 3'd1) || (cnt_q == 3'd3));
  // translation lane shifted left by 16 to the scale of a Q16.16 point times a coefficient
  assign mac_addend = (cnt_q == 3'd0) ? {lane16(shift_x_q, map_q), 16'h0000}
                                      : {lane16(shift_y_q, map_q), 16'h0000};

  ifs_cgp_mac #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .a_i      (mac_a),
    .b_i      (mac_b),
    .addend_i (mac_addend),
    .prod_o   (mac_prod),
    .point_o  (mac_point)
  );

  // column from x'*xscale (held product at step 5), row from y'*yscale in DONE
  assign col_v = ScrW'(mac_prod) + (ScrW'(lane16(screen_q, 2'd2)) <<< 16);
  assign row_v = HeightFix - ScrW'(mac_prod) + (ScrW'(lane16(screen_q, 2'd3)) <<< 16);
  assign on_y  = scr_on(row_v, HeightLim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
      point_x_q   <= '0;
      point_y_q   <= '0;
      coef_xx_q   <= '0;
      coef_xy_q   <= '0;
      coef_yx_q   <= '0;
      coef_yy_q   <= '0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      thr_q       <= '0;
      screen_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COEF_XX:    coef_xx_q <= cfg_wdata_i;
          REG_COEF_XY:    coef_xy_q <= cfg_wdata_i;
          REG_COEF_YX:    coef_yx_q <= cfg_wdata_i;
          REG_COEF_YY:    coef_yy_q <= cfg_wdata_i;
          REG_SHIFT_X:    shift_x_q <= cfg_wdata_i;
          REG_SHIFT_Y:    shift_y_q <= cfg_wdata_i;
          REG_THRESHOLDS: thr_q     <= cfg_wdata_i[3*ThrW-1:0];
          REG_SCREEN:     screen_q  <= cfg_wdata_i;
          default: ;  // drop writes beyond the register list
        endcase
      end

      // restart clears the point before the first product reads it
      if (in_acc && restart_i) begin
        point_x_q <= '0;
        point_y_q <= '0;
      end else if ((state_q == S_RUN) && (cnt_q == 3'd2)) begin
        point_x_q <= mac_point;
      end else if ((state_q == S_RUN) && (cnt_q == 3'd4)) begin
        point_y_q <= mac_point;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      map_q   <= map_d;
      color_q <= draw_color_i;
    end
    if ((state_q == S_RUN) && (cnt_q == 3'd5)) begin
      on_x_q <= scr_on(col_v, WidthLim);
      // a small negative sum truncates to column zero
      col_q  <= col_v[ScrW-1] ? 10'd0 : col_v[25:16];
    end
    if (out_load) begin
      plot_q  <= on_x_q && on_y;
      pix_x_q <= (on_x_q && on_y) ? col_q : 10'd0;
      pix_y_q <= (on_x_q && on_y && !row_v[ScrW-1]) ? row_v[24:16] : 9'd0;
      pix_c_q <= color_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_c_q;
  assign plot_enable_o = plot_q;

endmodule

FILE: hw/rtl/ifs_cgp_mac.sv
// Shared multiply-accumulate unit of the IFS plotter: registered 32x16 product,
// accumulator, floor shift and saturation to Q16.16. Depends on ifs_cgp_pkg.
module ifs_cgp_mac #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                   clk_i,
  input  ifs_cgp_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [ifs_cgp_pkg::PointW-1:0]  a_i,
  input  logic signed [ifs_cgp_pkg::CoefW-1:0]   b_i,
  input  logic signed [ifs_cgp_pkg::PointW-1:0]  addend_i,
  output logic signed [ifs_cgp_pkg::ProdW-1:0]   prod_o,
  output logic signed [ifs_cgp_pkg::PointW-1:0]  point_o
);
  import ifs_cgp_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  sum;
  logic signed [AccW-1:0]  shifted;
  logic signed [ProdW-1:0] mul;

  assign mul = ProdW'(a_i) * ProdW'(b_i);
  assign sum = acc_q + AccW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul;
    end
    if (ctrl_i.acc_init) begin
      acc_q <= AccW'(addend_i);
    end else if (ctrl_i.acc_add) begin
      acc_q <= sum;
    end
  end

  // floor division by 2^FRAC_BITS, then clamp to the signed 32-bit range
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    if ((&shifted[AccW-1:PointW-1]) || !(|shifted[AccW-1:PointW-1])) begin
      point_o = shifted[PointW-1:0];
    end else if (shifted[AccW-1]) begin
      point_o = {1'b1, {(PointW-1){1'b0}}};
    end else begin
      point_o = {1'b0, {(PointW-1){1'b1}}};
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/ifs_cgp_checker.sv
// Port-level checks for the IFS chaos-game plotter core and their binding.
// Sees only the top-level ports; depends on nothing but the core that it binds to.
module ifs_cgp_checker #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [9:0] pixel_x_o,
  input logic [8:0] pixel_y_o,
  input logic [3:0] pixel_color_o,
  input logic       plot_enable_o
);

  // after an accept, in_ready_o stays low through the six products and the pixel load
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
      ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input ready while an item is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({pixel_x_o, pixel_y_o, pixel_color_o, plot_enable_o}))
    else $error("stalled pixel item changed");

  a_off_screen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !plot_enable_o |-> pixel_x_o == 10'd0 && pixel_y_o == 9'd0)
    else $error("off-screen pixel item carries coordinates");

  a_on_screen_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && plot_enable_o |-> 32'(pixel_x_o) < SCREEN_WIDTH &&
      32'(pixel_y_o) < SCREEN_HEIGHT)
    else $error("plotted pixel outside the screen");

endmodule

bind ifs_chaos_game_plotter_core ifs_cgp_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ifs_cgp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_x_o     (pixel_x_o),
  .pixel_y_o     (pixel_y_o),
  .pixel_color_o (pixel_color_o),
  .plot_enable_o (plot_enable_o)
);

FILE: dv/testbench.sv
// Self-checking testbench for ifs_chaos_game_plotter_core: random and directed steps.
// Each pixel item is checked against an in-bench fixed-point chaos-game predictor.
// Depends on ifs_cgp_pkg for the configuration register indexes and widths.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifs_cgp_pkg::*;

  localparam int ScreenW  = 640;
  localparam int ScreenH  = 480;
  localparam int FracBits = 12;

  localparam longint PointMax = 64'sd2147483647;
  localparam longint PointMin = -64'sd2147483648;

  typedef struct {
    logic [14:0] random_value;
    logic [3:0]  color;
    logic        restart;
  } step_req_t;

  typedef struct {
    logic [9:0] x;
    logic [8:0] y;
    logic [3:0] color;
    logic       plot;
  } pixel_t;

  // every block input holds a known value from time zero
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  logic [IdxW-1:0]   cfg_idx      = '0;
  logic [CfgW-1:0]   cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic [14:0]       random_value = '0;
  logic [3:0]        draw_color   = '0;
  logic              restart      = 1'b0;
  logic              out_ready    = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [9:0]        pixel_x;
  logic [8:0]        pixel_y;
  logic [3:0]        pixel_color;
  logic              plot_enable;

  ifs_chaos_game_plotter_core #(
    .SCREEN_WIDTH  (ScreenW),
    .SCREEN_HEIGHT (ScreenH),
    .COEF_FRAC_BITS(FracBits)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .random_value_i(random_value),
    .draw_color_i  (draw_color),
    .restart_i     (restart),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .plot_enable_o (plot_enable)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers and of the current point.
  logic [CfgW-1:0] reg_shadow [8] = '{default: '0};
  int              point_x = 0;
  int              point_y = 0;

  step_req_t pending_steps [$];
  pixel_t    expected_pixels [$];
  int        steps_offered  = 0;
  int        steps_taken    = 0;
  int        pixels_checked = 0;
  int        mismatches     = 0;
  logic      step_taken     = 1'b0;

  // Sign-extend one 16-bit lane of a packed register.
  function automatic longint lane_of(logic [CfgW-1:0] word, int unsigned n);
    logic signed [15:0] v;
    v = word[n*16 +: 16];
    return longint'(v);
  endfunction

  function automatic longint clamp_point(longint v);
    if (v > PointMax) return PointMax;
    if (v < PointMin) return PointMin;
    return v;
  endfunction

  // Apply one chaos-game step to the shadow point and build the pixel it yields.
  function automatic pixel_t advance_point(step_req_t req);
    logic [ThrW-1:0] t0, t1, t2;
    int unsigned     map;
    longint          sum_x, sum_y, col, row;
    logic [CfgW-1:0] scr;
    logic            on;
    pixel_t          pix;
    t0  = reg_shadow[REG_THRESHOLDS][14:0];
    t1  = reg_shadow[REG_THRESHOLDS][29:15];
    t2  = reg_shadow[REG_THRESHOLDS][44:30];
    scr = reg_shadow[REG_SCREEN];
    if (req.restart) begin
      point_x = 0;
      point_y = 0;
    end
    // thresholds are tested in order, whether ascending or not
    if (req.random_value < t0) map = 0;
    else if (req.random_value < t1) map = 1;
    else if (req.random_value < t2) map = 2;
    else map = 3;
    sum_x = lane_of(reg_shadow[REG_COEF_XX], map) * longint'(point_x)
          + lane_of(reg_shadow[REG_COEF_XY], map) * longint'(point_y)
          + lane_of(reg_shadow[REG_SHIFT_X], map) * 65536;
    sum_y = lane_of(reg_shadow[REG_COEF_YX], map) * longint'(point_x)
          + lane_of(reg_shadow[REG_COEF_YY], map) * longint'(point_y)
          + lane_of(reg_shadow[REG_SHIFT_Y], map) * 65536;
    // arithmetic shift floors toward minus infinity, then saturate
    point_x = int'(clamp_point(sum_x >>> FracBits));
    point_y = int'(clamp_point(sum_y >>> FracBits));
    // signed division truncates toward zero; y is flipped against the screen height
    col = (longint'(point_x) * lane_of(scr, 0) + lane_of(scr, 2) * 65536) / 65536;
    row = (longint'(ScreenH) * 65536 - longint'(point_y) * lane_of(scr, 1)
           + lane_of(scr, 3) * 65536) / 65536;
    on = (col >= 0) && (col < ScreenW) && (row >= 0) && (row < ScreenH);
    pix.x     = on ? 10'(col) : '0;
    pix.y     = on ? 9'(row) : '0;
    pix.color = req.color;
    pix.plot  = on;
    return pix;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Sender: issue queued steps in bursts of random length with random gaps.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin : drive_steps
    step_req_t req;
    if (rst_n && (!in_valid || step_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_steps.size() > 0) begin
        req = pending_steps.pop_front();
        in_valid     <= 1'b1;
        random_value <= req.random_value;
        draw_color   <= req.color;
        restart      <= req.restart;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          // a quarter of the bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a rotating pattern that is redrawn whenever its age count runs out; once,
  // hold off for a long stretch so the block backs up and stalls its input.
  logic [15:0] stall_pattern = 16'hFFFF;
  int          pattern_age   = 0;
  int          hold_left     = 0;
  logic        hold_used     = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && pixels_checked >= 100) begin
      out_ready <= 1'b0;
      hold_left <= 300;
      hold_used <= 1'b1;
    end else begin
      out_ready <= stall_pattern[0];
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'h0001;
          default: stall_pattern <= 16'($urandom) | 16'h0001;
        endcase
        pattern_age <= 63;
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        pattern_age   <= pattern_age - 1;
      end
    end
  end

  // Monitor: predict on every accepted step, check every accepted pixel item.
  always @(posedge clk) begin : watch_ports
    step_req_t req;
    pixel_t    want;
    step_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req.random_value = random_value;
        req.color        = draw_color;
        req.restart      = restart;
        expected_pixels.push_back(advance_point(req));
        steps_taken++;
      end
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          flag_mismatch("unexpected pixel item, pixel_x", pixel_x, -1);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x !== want.x) flag_mismatch("pixel_x", pixel_x, want.x);
          if (pixel_y !== want.y) flag_mismatch("pixel_y", pixel_y, want.y);
          if (pixel_color !== want.color) flag_mismatch("pixel_color", pixel_color, want.color);
          if (plot_enable !== want.plot) flag_mismatch("plot_enable", plot_enable, want.plot);
        end
      end
    end
  end

  function automatic logic [CfgW-1:0] pack4(int l0, int l1, int l2, int l3);
    return {16'(l3), 16'(l2), 16'(l1), 16'(l0)};
  endfunction

  function automatic logic [CfgW-1:0] pack_thresholds(int t0, int t1, int t2);
    return CfgW'({15'(t2), 15'(t1), 15'(t0)});
  endfunction

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    reg_shadow[idx] = (idx == REG_THRESHOLDS) ? (value & 64'h1FFF_FFFF_FFFF) : value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [CfgW-1:0] value);
    for (int i = 0; i < 8; i++) write_reg(IdxW'(i), value);
  endtask

  task automatic offer_step(int r, int color, bit clear);
    step_req_t req;
    req.random_value = 15'(r);
    req.color        = 4'(color);
    req.restart      = clear;
    pending_steps.push_back(req);
    steps_offered++;
  endtask

  // Block the caller until every offered step is taken and every pixel has come back.
  task automatic drain();
    while (steps_taken != steps_offered || expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic random_steps(int count, int restart_odds);
    for (int i = 0; i < count; i++)
      offer_step($urandom_range(0, 32767), $urandom_range(0, 15),
                 $urandom_range(1, restart_odds) == 1);
    drain();
  endtask

  function automatic int coef_draw(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic int sort3_pick(int a, int b, int c, int which);
    int lo, mid, hi;
    lo  = (a < b) ? ((a < c) ? a : c) : ((b < c) ? b : c);
    hi  = (a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c);
    mid = a + b + c - lo - hi;
    return (which == 0) ? lo : (which == 1) ? mid : hi;
  endfunction

  // Load maps: contractive ones that keep the point near the screen, or raw bits.
  task automatic load_random_maps(bit wild);
    int a, b, c;
    if (wild) begin
      for (int i = 0; i < 8; i++) write_reg(IdxW'(i), {$urandom, $urandom});
    end else begin
      write_reg(REG_COEF_XX, pack4(coef_draw(1843), coef_draw(1843), coef_draw(1843),
                                   coef_draw(1843)));
      write_reg(REG_COEF_XY, pack4(coef_draw(1843), coef_draw(1843), coef_draw(1843),
                                   coef_draw(1843)));
      write_reg(REG_COEF_YX, pack4(coef_draw(1843), coef_draw(1843), coef_draw(1843),
                                   coef_draw(1843)));
      write_reg(REG_COEF_YY, pack4(coef_draw(1843), coef_draw(1843), coef_draw(1843),
                                   coef_draw(1843)));
      write_reg(REG_SHIFT_X, pack4(coef_draw(8192), coef_draw(8192), coef_draw(8192),
                                   coef_draw(8192)));
      write_reg(REG_SHIFT_Y, pack4(coef_draw(8192), coef_draw(8192), coef_draw(8192),
                                   coef_draw(8192)));
      a = $urandom_range(0, 32767);
      b = $urandom_range(0, 32767);
      c = $urandom_range(0, 32767);
      write_reg(REG_THRESHOLDS, pack_thresholds(sort3_pick(a, b, c, 0), sort3_pick(a, b, c, 1),
                                                sort3_pick(a, b, c, 2)));
      write_reg(REG_SCREEN, pack4($urandom_range(10, 60), coef_draw(60),
                                  $urandom_range(0, 640), coef_draw(240)));
    end
  endtask

  initial begin
    // hold reset low, then release it on a falling edge, away from the rising edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Registers at reset: the point never leaves the origin, row lands just off screen.
    offer_step(0, 0, 1'b0);
    offer_step(32767, 15, 1'b1);
    drain();

    // Fern maps; probe each threshold boundary and both ends of the random range.
    write_reg(REG_COEF_XX, pack4(0, 3482, 819, -614));
    write_reg(REG_COEF_XY, pack4(0, 164, -1065, 1147));
    write_reg(REG_COEF_YX, pack4(0, -164, 942, 1065));
    write_reg(REG_COEF_YY, pack4(655, 3482, 901, 983));
    write_reg(REG_SHIFT_X, pack4(0, 0, 0, 0));
    write_reg(REG_SHIFT_Y, pack4(0, 6554, 6554, 1802));
    write_reg(REG_THRESHOLDS, pack_thresholds(328, 28181, 30475));
    write_reg(REG_SCREEN, pack4(60, 45, 320, 0));
    offer_step(0, 0, 1'b0);
    offer_step(327, 15, 1'b0);
    offer_step(328, 5, 1'b0);
    offer_step(28180, 10, 1'b0);
    offer_step(28181, 3, 1'b0);
    offer_step(30474, 12, 1'b1);
    offer_step(30475, 7, 1'b0);
    offer_step(32767, 9, 1'b0);
    offer_step(32766, 6, 1'b0);
    drain();

    // Thresholds out of order and the largest coefficients: drive the point into saturation.
    write_reg(REG_COEF_XX, pack4(32767, 32767, 32767, 32767));
    write_reg(REG_COEF_YY, pack4(32767, -32768, 32767, -32768));
    write_reg(REG_SHIFT_X, pack4(32767, -32768, 32767, -32768));
    write_reg(REG_SHIFT_Y, pack4(-32768, 32767, -32768, 32767));
    write_reg(REG_THRESHOLDS, pack_thresholds(20000, 5000, 30000));
    write_reg(REG_SCREEN, pack4(-32768, 32767, 100, -200));
    for (int i = 0; i < 8; i++)
      offer_step((i * 9973) % 32768, i, i == 0);
    drain();

    // Long fern run; pause halfway until every pixel is back.
    write_reg(REG_COEF_YY, pack4(655, 3482, 901, 983));
    write_reg(REG_SHIFT_X, pack4(0, 0, 0, 0));
    write_reg(REG_SHIFT_Y, pack4(0, 6554, 6554, 1802));
    write_reg(REG_THRESHOLDS, pack_thresholds(328, 28181, 30475));
    write_reg(REG_SCREEN, pack4(60, 45, 320, 0));
    write_reg(REG_COEF_XX, pack4(0, 3482, 819, -614));
    random_steps(200, 100);
    random_steps(200, 100);

    for (int p = 0; p < 6; p++) begin
      load_random_maps(1'b0);
      random_steps(80, 30);
    end
    for (int p = 0; p < 2; p++) begin
      load_random_maps(1'b1);
      random_steps(60, 20);
    end

    // Extreme register values, then back to all zeros.
    write_all('1);
    random_steps(40, 10);
    write_all({4{16'h8000}});
    random_steps(40, 10);
    write_all({4{16'h7FFF}});
    random_steps(40, 10);
    write_all('0);
    random_steps(20, 5);

    // let any stray pixel item surface before the verdict
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ifs_cgp_pkg.sv
hw/rtl/ifs_cgp_mac.sv
hw/rtl/ifs_chaos_game_plotter_core.sv
hw/rtl/ifs_cgp_checker.sv
dv/testbench.sv
